// File: hw/rtl/phm_pkg.sv
// Shared definitions for the pad hit map table: default geometry, function
// codes, pad status codes and payload widths.
// No dependencies.
package phm_pkg;

  localparam int unsigned NUM_SECTORS_DEF = 18;
  localparam int unsigned NUM_PLATES_DEF  = 5;
  localparam int unsigned NUM_STRIPS_DEF  = 20;
  localparam int unsigned PADS_X_DEF      = 48;
  localparam int unsigned PADS_Z_DEF      = 2;

  localparam int unsigned ENTRY_W = 16;
  localparam int unsigned RIDX_W  = 17;

  localparam logic [1:0] FUNC_WRITE = 2'd0;
  localparam logic [1:0] FUNC_READ  = 2'd1;
  localparam logic [1:0] FUNC_CLEAR = 2'd2;

  localparam logic [1:0] STATUS_EMPTY  = 2'd0;
  localparam logic [1:0] STATUS_USED   = 2'd1;
  localparam logic [1:0] STATUS_UNUSED = 2'd2;

  localparam logic signed [RIDX_W-1:0] READ_INDEX_NONE = -17'sd1;

endpackage

// File: hw/rtl/pad_hit_map_table.sv
// Pad hit map table, top level: command sequencer around the index unit and
// the pad store. Depends on phm_pkg, phm_index and phm_store.
//
// An item is taken when start is high and busy is low; its single result
// appears for one cycle with out_valid and cannot be held off. A write loads
// the index unit, runs its four radix steps and then writes the store; a read
// runs the same steps, then reads the store and gives its registered read
// data. An out-of-range item or an unused function code gives its result
// without these steps. A clear walks the store one entry per cycle over all
// NUM_SECTORS*NUM_PLATES*NUM_STRIPS*PADS_X*PADS_Z entries; the same pass runs
// after reset (172800 entries at the default geometry) with busy high and no
// result.
module pad_hit_map_table #(
  parameter int unsigned NUM_SECTORS = phm_pkg::NUM_SECTORS_DEF,
  parameter int unsigned NUM_PLATES  = phm_pkg::NUM_PLATES_DEF,
  parameter int unsigned NUM_STRIPS  = phm_pkg::NUM_STRIPS_DEF,
  parameter int unsigned PADS_X      = phm_pkg::PADS_X_DEF,
  parameter int unsigned PADS_Z      = phm_pkg::PADS_Z_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         in_func,
  input  logic [4:0]         in_sector,
  input  logic [2:0]         in_plate,
  input  logic [4:0]         in_strip,
  input  logic [5:0]         in_pad_x,
  input  logic [1:0]         in_pad_z,
  input  logic signed [15:0] in_digit_index,
  output logic               out_valid,
  output logic signed [16:0] out_read_index,
  output logic [1:0]         out_pad_status,
  output logic               out_out_of_range
);

  localparam int unsigned DEPTH = NUM_SECTORS * NUM_PLATES * NUM_STRIPS * PADS_X * PADS_Z;
  localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned EW = phm_pkg::ENTRY_W;
  localparam int unsigned RW = phm_pkg::RIDX_W;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_INDEX = 3'd1;
  localparam logic [2:0] ST_READ  = 3'd2;
  localparam logic [2:0] ST_CLEAR = 3'd3;

  logic [2:0]           state_r, state_nxt;
  logic [ADDR_W-1:0]    ptr_r, ptr_nxt;
  logic                 clr_reply_r, clr_reply_nxt;
  logic [1:0]           func_r, func_nxt;
  logic [EW-1:0]        store_val_r, store_val_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic signed [RW-1:0] ridx_r, ridx_nxt;
  logic [1:0]           status_r, status_nxt;
  logic                 oor_r, oor_nxt;

  logic                 accept;
  logic                 in_range;
  logic                 is_wr;
  logic                 idx_start;
  logic                 idx_done;
  logic [ADDR_W-1:0]    idx_value;
  logic                 mem_we;
  logic [ADDR_W-1:0]    mem_addr;
  logic [EW-1:0]        mem_wdata;
  logic [EW-1:0]        mem_rdata;
  logic signed [RW-1:0] rd_ext;

  assign accept = start && !busy;
  assign busy   = (state_r != ST_IDLE);
  assign is_wr  = (in_func == phm_pkg::FUNC_WRITE) || (in_func == phm_pkg::FUNC_READ);
  assign in_range = (in_sector != 5'd0) && (in_sector <= 5'(NUM_SECTORS)) &&
                    (in_plate  != 3'd0) && (in_plate  <= 3'(NUM_PLATES))  &&
                    (in_strip  != 5'd0) && (in_strip  <= 5'(NUM_STRIPS))  &&
                    (in_pad_x  != 6'd0) && (in_pad_x  <= 6'(PADS_X))      &&
                    (in_pad_z  != 2'd0) && (in_pad_z  <= 2'(PADS_Z));
  assign rd_ext = {mem_rdata[EW-1], mem_rdata};

  phm_index #(
    .NUM_PLATES (NUM_PLATES),
    .NUM_STRIPS (NUM_STRIPS),
    .PADS_X     (PADS_X),
    .PADS_Z     (PADS_Z),
    .ADDR_W     (ADDR_W)
  ) u_index (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (idx_start),
    .sector (in_sector),
    .plate  (in_plate),
    .strip  (in_strip),
    .pad_x  (in_pad_x),
    .pad_z  (in_pad_z),
    .done   (idx_done),
    .index  (idx_value)
  );

  phm_store #(
    .DEPTH  (DEPTH),
    .ADDR_W (ADDR_W)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

  always_comb begin
    state_nxt     = state_r;
    ptr_nxt       = ptr_r;
    clr_reply_nxt = clr_reply_r;
    func_nxt      = func_r;
    store_val_nxt = store_val_r;
    out_valid_nxt = 1'b0;
    ridx_nxt      = ridx_r;
    status_nxt    = status_r;
    oor_nxt       = oor_r;
    idx_start     = 1'b0;
    mem_we        = 1'b0;
    mem_addr      = idx_value;
    mem_wdata     = store_val_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          func_nxt      = in_func;
          store_val_nxt = EW'($unsigned(in_digit_index) + 16'd1);
          if (in_func == phm_pkg::FUNC_CLEAR) begin
            state_nxt     = ST_CLEAR;
            ptr_nxt       = '0;
            clr_reply_nxt = 1'b1;
          end else if (is_wr && in_range) begin
            idx_start = 1'b1;
            state_nxt = ST_INDEX;
          end else begin
            out_valid_nxt = 1'b1;
            ridx_nxt      = (in_func == phm_pkg::FUNC_READ) ? phm_pkg::READ_INDEX_NONE : '0;
            status_nxt    = phm_pkg::STATUS_EMPTY;
            oor_nxt       = is_wr;
          end
        end
      end
      ST_INDEX: begin
        if (idx_done) begin
          if (func_r == phm_pkg::FUNC_WRITE) begin
            mem_we        = 1'b1;
            out_valid_nxt = 1'b1;
            ridx_nxt      = '0;
            status_nxt    = phm_pkg::STATUS_EMPTY;
            oor_nxt       = 1'b0;
            state_nxt     = ST_IDLE;
          end else begin
            state_nxt = ST_READ;
          end
        end
      end
      ST_READ: begin
        out_valid_nxt = 1'b1;
        ridx_nxt      = rd_ext - 17'sd1;
        oor_nxt       = 1'b0;
        if (mem_rdata == '0) begin
          status_nxt = phm_pkg::STATUS_EMPTY;
        end else if (mem_rdata[EW-1]) begin
          status_nxt = phm_pkg::STATUS_UNUSED;
        end else begin
          status_nxt = phm_pkg::STATUS_USED;
        end
        state_nxt = ST_IDLE;
      end
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_addr  = ptr_r;
        mem_wdata = '0;
        ptr_nxt   = ptr_r + ADDR_W'(1);
        if (ptr_r == ADDR_W'(DEPTH - 1)) begin
          state_nxt     = ST_IDLE;
          ptr_nxt       = '0;
          clr_reply_nxt = 1'b0;
          if (clr_reply_r) begin
            out_valid_nxt = 1'b1;
            ridx_nxt      = '0;
            status_nxt    = phm_pkg::STATUS_EMPTY;
            oor_nxt       = 1'b0;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      ptr_r       <= '0;
      clr_reply_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ptr_r       <= ptr_nxt;
      clr_reply_r <= clr_reply_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    func_r      <= func_nxt;
    store_val_r <= store_val_nxt;
    ridx_r      <= ridx_nxt;
    status_r    <= status_nxt;
    oor_r       <= oor_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_read_index   = ridx_r;
  assign out_pad_status   = status_r;
  assign out_out_of_range = oor_r;

`ifndef SYNTHESIS
  a_accept_tracked: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (busy || out_valid))
    else $error("accepted transfer neither occupies the block nor gives a result");

  a_index_done_in_index: assert property (@(posedge clk) disable iff (!rst_n)
    idx_done |-> (state_r == ST_INDEX))
    else $error("index unit finished outside the index state");

  a_read_follows_index: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_READ) |-> ($past(state_r) == ST_INDEX))
    else $error("read state entered without an index lookup");

  a_reset_sweep_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CLEAR && !clr_reply_r) |=> !out_valid_r)
    else $error("reset clearing pass produced a result");

  a_no_write_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> !mem_we)
    else $error("store written while idle");
`endif

endmodule

// File: hw/rtl/phm_store.sv
// Single-port synchronous store for the pad hit map, one entry per pad.
// Read data is registered; depends on phm_pkg for the entry width.
module phm_store #(
  parameter int unsigned DEPTH  = 2,
  parameter int unsigned ADDR_W = 1
) (
  input  logic                             clk,
  input  logic                             we,
  input  logic [ADDR_W-1:0]                addr,
  input  logic [phm_pkg::ENTRY_W-1:0]      wdata,
  output logic [phm_pkg::ENTRY_W-1:0]      rdata
);

  logic [phm_pkg::ENTRY_W-1:0] mem [DEPTH];
  logic [phm_pkg::ENTRY_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata_r <= mem[addr];
  end

  assign rdata = rdata_r;

endmodule

// File: hw/rtl/phm_index.sv
// Iterative mixed-radix index unit: folds the five 1-based pad coordinates
// into a flat store address, one radix step per cycle. No package use.
module phm_index #(
  parameter int unsigned NUM_PLATES = 5,
  parameter int unsigned NUM_STRIPS = 20,
  parameter int unsigned PADS_X     = 48,
  parameter int unsigned PADS_Z     = 2,
  parameter int unsigned ADDR_W     = 18
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [4:0]        sector,
  input  logic [2:0]        plate,
  input  logic [4:0]        strip,
  input  logic [5:0]        pad_x,
  input  logic [1:0]        pad_z,
  output logic              done,
  output logic [ADDR_W-1:0] index
);

  localparam logic [1:0] STEP_PLATE = 2'd0;
  localparam logic [1:0] STEP_STRIP = 2'd1;
  localparam logic [1:0] STEP_PADX  = 2'd2;
  localparam logic [1:0] STEP_PADZ  = 2'd3;
  localparam int unsigned PROD_W = ADDR_W + 6;

  logic              run_r, run_nxt;
  logic              done_r, done_nxt;
  logic [1:0]        step_r, step_nxt;
  logic [ADDR_W-1:0] acc_r, acc_nxt;
  logic [2:0]        plate_r;
  logic [4:0]        strip_r;
  logic [5:0]        pad_x_r;
  logic [1:0]        pad_z_r;
  logic [5:0]        radix_sel;
  logic [5:0]        digit_sel;
  logic [PROD_W-1:0] prod;

  always_comb begin
    case (step_r)
      STEP_PLATE: begin
        radix_sel = 6'(NUM_PLATES);
        digit_sel = 6'(plate_r);
      end
      STEP_STRIP: begin
        radix_sel = 6'(NUM_STRIPS);
        digit_sel = 6'(strip_r);
      end
      STEP_PADX: begin
        radix_sel = 6'(PADS_X);
        digit_sel = pad_x_r;
      end
      STEP_PADZ: begin
        radix_sel = 6'(PADS_Z);
        digit_sel = 6'(pad_z_r);
      end
      default: begin
        radix_sel = 6'd0;
        digit_sel = 6'd0;
      end
    endcase
    prod = PROD_W'(acc_r) * PROD_W'(radix_sel) + PROD_W'(digit_sel);
  end

  always_comb begin
    run_nxt  = run_r;
    done_nxt = 1'b0;
    step_nxt = step_r;
    acc_nxt  = acc_r;
    if (start) begin
      run_nxt  = 1'b1;
      step_nxt = STEP_PLATE;
      acc_nxt  = ADDR_W'(sector - 5'd1);
    end else if (run_r) begin
      acc_nxt  = ADDR_W'(prod);
      step_nxt = step_r + 2'd1;
      if (step_r == STEP_PADZ) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      step_r <= STEP_PLATE;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
      step_r <= step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
    if (start) begin
      plate_r <= plate - 3'd1;
      strip_r <= strip - 5'd1;
      pad_x_r <= pad_x - 6'd1;
      pad_z_r <= pad_z - 2'd1;
    end
  end

  assign done  = done_r;
  assign index = acc_r;

endmodule

// File: tb/sv/tb_top.sv
// Self-checking testbench for pad_hit_map_table: a directed table, then random
// writes, reads, clears, unused function codes and out-of-range items, all
// checked against a predictor. Depends on phm_pkg and the pad_hit_map_table RTL.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import phm_pkg::*;

  localparam logic [1:0] FUNC_UNUSED = 2'd3;
  localparam int unsigned STORE_DEPTH =
    NUM_SECTORS_DEF * NUM_PLATES_DEF * NUM_STRIPS_DEF * PADS_X_DEF * PADS_Z_DEF;
  localparam int RANDOM_ITEMS = 900;
  localparam int POOL_MAX = 64;

  typedef struct packed {
    logic [1:0]  func;
    logic [4:0]  sector;
    logic [2:0]  plate;
    logic [4:0]  strip;
    logic [5:0]  pad_x;
    logic [1:0]  pad_z;
    logic [15:0] digit;
  } pad_cmd_t;

  typedef struct packed {
    logic [16:0] read_index;
    logic [1:0]  status;
    logic        oor;
  } pad_result_t;

  typedef struct packed {
    pad_cmd_t    cmd;
    logic        known;
    pad_result_t res;
  } pad_row_t;

  localparam pad_result_t ZERO_RES = '{17'd0, STATUS_EMPTY, 1'b0};
  localparam logic [16:0] NONE = READ_INDEX_NONE;

  logic               clk;
  logic               rst_n = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  logic [1:0]         in_func = FUNC_WRITE;
  logic [4:0]         in_sector = '0;
  logic [2:0]         in_plate = '0;
  logic [4:0]         in_strip = '0;
  logic [5:0]         in_pad_x = '0;
  logic [1:0]         in_pad_z = '0;
  logic signed [15:0] in_digit_index = '0;
  logic               out_valid;
  logic signed [16:0] out_read_index;
  logic [1:0]         out_pad_status;
  logic               out_out_of_range;

  logic [15:0] pad_store [int];
  pad_result_t pending_results [$];
  pad_cmd_t    written_pads [$];
  int          mismatches = 0;
  int          gapless_left = 0;
  pad_row_t    directed [25];

  pad_hit_map_table uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_func          (in_func),
    .in_sector        (in_sector),
    .in_plate         (in_plate),
    .in_strip         (in_strip),
    .in_pad_x         (in_pad_x),
    .in_pad_z         (in_pad_z),
    .in_digit_index   (in_digit_index),
    .out_valid        (out_valid),
    .out_read_index   (out_read_index),
    .out_pad_status   (out_pad_status),
    .out_out_of_range (out_out_of_range)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #40_000_000;
    $display("pad_hit_map_table test failed");
    $finish;
  end

  function automatic pad_result_t predict_pad(pad_cmd_t c);
    pad_result_t r;
    bit          ok;
    int          idx;
    int          stored;
    r = ZERO_RES;
    if (c.func == FUNC_CLEAR) begin
      pad_store.delete();
    end else if (c.func == FUNC_WRITE || c.func == FUNC_READ) begin
      ok = c.sector >= 1 && c.sector <= NUM_SECTORS_DEF &&
           c.plate >= 1 && c.plate <= NUM_PLATES_DEF &&
           c.strip >= 1 && c.strip <= NUM_STRIPS_DEF &&
           c.pad_x >= 1 && c.pad_x <= PADS_X_DEF &&
           c.pad_z >= 1 && c.pad_z <= PADS_Z_DEF;
      if (!ok) begin
        r.oor = 1'b1;
        if (c.func == FUNC_READ) r.read_index = NONE;
      end else begin
        idx = int'(c.sector) - 1;
        idx = idx * NUM_PLATES_DEF + int'(c.plate) - 1;
        idx = idx * NUM_STRIPS_DEF + int'(c.strip) - 1;
        idx = idx * PADS_X_DEF + int'(c.pad_x) - 1;
        idx = idx * PADS_Z_DEF + int'(c.pad_z) - 1;
        if (c.func == FUNC_WRITE) begin
          pad_store[idx] = c.digit + 16'd1;
        end else begin
          stored = pad_store.exists(idx) ? int'($signed(pad_store[idx])) : 0;
          r.read_index = 17'(stored - 1);
          r.status = stored > 0 ? STATUS_USED : (stored == 0 ? STATUS_EMPTY : STATUS_UNUSED);
        end
      end
    end
    return r;
  endfunction

  function automatic pad_cmd_t random_cmd();
    pad_cmd_t c;
    int       pick;
    int       dpick;
    pick = $urandom_range(0, 99);
    c.func = pick < 40 ? FUNC_WRITE : (pick < 95 ? FUNC_READ : FUNC_UNUSED);
    if (pick >= 85) begin
      c.sector = 5'($urandom);
      c.plate = 3'($urandom);
      c.strip = 5'($urandom);
      c.pad_x = 6'($urandom);
      c.pad_z = 2'($urandom);
    end else if (written_pads.size() > 0 &&
                 $urandom_range(0, 99) < (c.func == FUNC_READ ? 75 : 30)) begin
      c = written_pads[$urandom_range(0, written_pads.size() - 1)];
      c.func = pick < 40 ? FUNC_WRITE : FUNC_READ;
    end else begin
      c.sector = 5'($urandom_range(1, NUM_SECTORS_DEF));
      c.plate = 3'($urandom_range(1, NUM_PLATES_DEF));
      c.strip = 5'($urandom_range(1, NUM_STRIPS_DEF));
      c.pad_x = 6'($urandom_range(1, PADS_X_DEF));
      c.pad_z = 2'($urandom_range(1, PADS_Z_DEF));
    end
    dpick = $urandom_range(0, 9);
    c.digit = dpick == 0 ? 16'h7FFF : (dpick == 1 ? 16'h8000 :
              (dpick == 2 ? 16'hFFFF : 16'($urandom)));
    return c;
  endfunction

  task automatic send_cmd(pad_cmd_t c);
    start <= 1'b1;
    in_func <= c.func;
    in_sector <= c.sector;
    in_plate <= c.plate;
    in_strip <= c.strip;
    in_pad_x <= c.pad_x;
    in_pad_z <= c.pad_z;
    in_digit_index <= c.digit;
    do @(posedge clk); while (busy);
  endtask

  task automatic idle_gap();
    int pick;
    int gap;
    pick = $urandom_range(0, 99);
    if (gapless_left > 0) begin
      gapless_left--;
      gap = 0;
    end else if (pick < 3) begin
      gapless_left = $urandom_range(10, 40);
      gap = 0;
    end else if (pick < 45) begin
      gap = 0;
    end else if (pick < 85) begin
      gap = $urandom_range(1, 3);
    end else if (pick < 95) begin
      gap = $urandom_range(4, 10);
    end else begin
      gap = $urandom_range(20, 60);
    end
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_drain();
    start <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  always @(posedge clk) begin : result_check
    pad_result_t got;
    pad_result_t want;
    if (rst_n && out_valid) begin
      got = '{out_read_index, out_pad_status, out_out_of_range};
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: result with nothing pending: read_index %0d status %0d oor %0b",
                   $realtime, $signed(got.read_index), got.status, got.oor);
      end else begin
        want = pending_results.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: expected read_index %0d status %0d oor %0b, got %0d %0d %0b",
                     $realtime, $signed(want.read_index), want.status, want.oor,
                     $signed(got.read_index), got.status, got.oor);
        end
      end
    end
  end

  initial begin : stimulus
    pad_cmd_t    c;
    pad_result_t r;
    int          clear_a;
    int          clear_b;

    directed = '{
      '{'{FUNC_READ,   5'd1,  3'd1, 5'd1,  6'd1,  2'd1, 16'h0000}, 1'b1,
        '{NONE, STATUS_EMPTY, 1'b0}},
      '{'{FUNC_WRITE,  5'd1,  3'd1, 5'd1,  6'd1,  2'd1, 16'h8000}, 1'b1, ZERO_RES},
      '{'{FUNC_READ,   5'd1,  3'd1, 5'd1,  6'd1,  2'd1, 16'h0000}, 1'b1,
        '{17'h18000, STATUS_UNUSED, 1'b0}},
      '{'{FUNC_WRITE,  5'd18, 3'd5, 5'd20, 6'd48, 2'd2, 16'h7FFF}, 1'b1, ZERO_RES},
      '{'{FUNC_READ,   5'd18, 3'd5, 5'd20, 6'd48, 2'd2, 16'h0000}, 1'b1,
        '{17'h17FFF, STATUS_UNUSED, 1'b0}},
      '{'{FUNC_WRITE,  5'd18, 3'd5, 5'd20, 6'd48, 2'd1, 16'h0000}, 1'b1, ZERO_RES},
      '{'{FUNC_READ,   5'd18, 3'd5, 5'd20, 6'd48, 2'd1, 16'h0000}, 1'b1,
        '{17'd0, STATUS_USED, 1'b0}},
      '{'{FUNC_WRITE,  5'd2,  3'd3, 5'd4,  6'd5,  2'd1, 16'h7FFE}, 1'b0, ZERO_RES},
      '{'{FUNC_READ,   5'd2,  3'd3, 5'd4,  6'd5,  2'd1, 16'h0000}, 1'b0, ZERO_RES},
      '{'{FUNC_WRITE,  5'd3,  3'd1, 5'd1,  6'd1,  2'd1, 16'hFFFF}, 1'b0, ZERO_RES},
      '{'{FUNC_READ,   5'd3,  3'd1, 5'd1,  6'd1,  2'd1, 16'h0000}, 1'b0, ZERO_RES},
      '{'{FUNC_WRITE,  5'd9,  3'd2, 5'd10, 6'd24, 2'd2, 16'h1234}, 1'b0, ZERO_RES},
      '{'{FUNC_READ,   5'd9,  3'd2, 5'd10, 6'd24, 2'd2, 16'h0000}, 1'b0, ZERO_RES},
      '{'{FUNC_WRITE,  5'd0,  3'd1, 5'd1,  6'd1,  2'd1, 16'h5555}, 1'b1,
        '{17'd0, STATUS_EMPTY, 1'b1}},
      '{'{FUNC_READ,   5'd19, 3'd1, 5'd1,  6'd1,  2'd1, 16'h0000}, 1'b1,
        '{NONE, STATUS_EMPTY, 1'b1}},
      '{'{FUNC_WRITE,  5'd1,  3'd6, 5'd1,  6'd1,  2'd1, 16'h0001}, 1'b1,
        '{17'd0, STATUS_EMPTY, 1'b1}},
      '{'{FUNC_READ,   5'd1,  3'd7, 5'd31, 6'd1,  2'd1, 16'h0000}, 1'b1,
        '{NONE, STATUS_EMPTY, 1'b1}},
      '{'{FUNC_WRITE,  5'd1,  3'd1, 5'd21, 6'd1,  2'd1, 16'hAAAA}, 1'b1,
        '{17'd0, STATUS_EMPTY, 1'b1}},
      '{'{FUNC_READ,   5'd1,  3'd1, 5'd1,  6'd49, 2'd1, 16'h0000}, 1'b1,
        '{NONE, STATUS_EMPTY, 1'b1}},
      '{'{FUNC_WRITE,  5'd31, 3'd1, 5'd1,  6'd63, 2'd3, 16'h0002}, 1'b1,
        '{17'd0, STATUS_EMPTY, 1'b1}},
      '{'{FUNC_READ,   5'd1,  3'd1, 5'd1,  6'd1,  2'd0, 16'h0000}, 1'b1,
        '{NONE, STATUS_EMPTY, 1'b1}},
      '{'{FUNC_UNUSED, 5'd31, 3'd7, 5'd31, 6'd63, 2'd3, 16'hFFFF}, 1'b1, ZERO_RES},
      '{'{FUNC_CLEAR,  5'd31, 3'd7, 5'd31, 6'd63, 2'd3, 16'hFFFF}, 1'b1, ZERO_RES},
      '{'{FUNC_READ,   5'd1,  3'd1, 5'd1,  6'd1,  2'd1, 16'h0000}, 1'b1,
        '{NONE, STATUS_EMPTY, 1'b0}},
      '{'{FUNC_READ,   5'd18, 3'd5, 5'd20, 6'd48, 2'd2, 16'h0000}, 1'b1,
        '{NONE, STATUS_EMPTY, 1'b0}}
    };

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed[i]) begin
      if (directed[i].cmd.func == FUNC_CLEAR) wait_drain();
      send_cmd(directed[i].cmd);
      r = predict_pad(directed[i].cmd);
      pending_results.push_back(directed[i].known ? directed[i].res : r);
      idle_gap();
    end

    clear_a = $urandom_range(100, 400);
    clear_b = $urandom_range(500, 850);
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == clear_a || n == clear_b) begin
        wait_drain();
        c = random_cmd();
        c.func = FUNC_CLEAR;
        c.sector = 5'($urandom);
        c.plate = 3'($urandom);
        c.strip = 5'($urandom);
        c.pad_x = 6'($urandom);
        c.pad_z = 2'($urandom);
      end else begin
        c = random_cmd();
      end
      send_cmd(c);
      r = predict_pad(c);
      pending_results.push_back(r);
      if (c.func == FUNC_WRITE && !r.oor) begin
        written_pads.push_back(c);
        if (written_pads.size() > POOL_MAX) void'(written_pads.pop_front());
      end
      idle_gap();
    end

    wait_drain();
    repeat (20) @(posedge clk);
    if (mismatches == 0)
      $display("pad_hit_map_table test passed");
    else
      $display("pad_hit_map_table test failed");
    $finish;
  end

endmodule

// File: filelist.f
hw/rtl/phm_pkg.sv
hw/rtl/phm_store.sv
hw/rtl/phm_index.sv
hw/rtl/pad_hit_map_table.sv
tb/sv/tb_top.sv
